@@ rtl/nks_pkg.sv @@
// Package for the nearest-K point selector: sizes, payload structs, register codes.
// Used by every module in rtl; it depends on nothing else.
package nks_pkg;

	localparam int KEEP_COUNT = 8;
	localparam int ID_BITS    = 10;
	localparam int COORD_BITS = 16;
	localparam int DIST_BITS  = 34;
	localparam int SQ_BITS    = 32;
	localparam int RANK_BITS  = 3;
	localparam int CFG_BITS   = 2;

	// Configuration register indexes.
	localparam logic [CFG_BITS-1:0] CFG_QUERY_X = 2'd0;
	localparam logic [CFG_BITS-1:0] CFG_QUERY_Y = 2'd1;
	localparam logic [CFG_BITS-1:0] CFG_QUERY_Z = 2'd2;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	// One candidate point as it arrives.
	typedef struct packed {
		logic [ID_BITS-1:0] point_id;
		coord_t             point_x;
		coord_t             point_y;
		coord_t             point_z;
		logic               batch_end;
	} in_t;

	// One result as it leaves.
	typedef struct packed {
		logic [RANK_BITS-1:0] rank;
		logic [ID_BITS-1:0]   chosen_id;
		logic [DIST_BITS-1:0] distance_sq;
		logic                 final_result;
	} out_t;

	// A candidate with its distance, ready to enter the cell chain.
	typedef struct packed {
		logic                 valid;
		logic                 last;
		logic [ID_BITS-1:0]   id;
		logic [DIST_BITS-1:0] distance;
	} cand_t;

	// The contents of one cell of the chain.
	typedef struct packed {
		logic                 valid;
		logic [ID_BITS-1:0]   id;
		logic [DIST_BITS-1:0] distance;
	} entry_t;

	// Control broadcast to every cell.
	typedef struct packed {
		logic ins;
		logic shift;
	} cell_ctl_t;

endpackage

@@ rtl/nks_dist.sv @@
// Three-stage pipelined squared-distance unit of the nearest-K point selector.
// Depends on nks_pkg.
module nks_dist (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_take,
	input  nks_pkg::in_t  in_item,
	input  nks_pkg::coord_t query_x,
	input  nks_pkg::coord_t query_y,
	input  nks_pkg::coord_t query_z,
	output nks_pkg::cand_t cand
);

	logic [nks_pkg::COORD_BITS:0]   dx, dy, dz;
	logic [nks_pkg::COORD_BITS-1:0] mx_s1, my_s1, mz_s1;
	logic [nks_pkg::SQ_BITS-1:0]    sx_s2, sy_s2, sz_s2;
	logic [nks_pkg::ID_BITS-1:0]    id_s1, id_s2, id_s3;
	logic                           vld_s1, vld_s2, vld_s3, last_s1, last_s2, last_s3;
	logic [nks_pkg::DIST_BITS-1:0]  dist_s3;

	// Differences in 17 bits, signed.
	assign dx = {in_item.point_x[nks_pkg::COORD_BITS-1], in_item.point_x}
		- {query_x[nks_pkg::COORD_BITS-1], query_x};
	assign dy = {in_item.point_y[nks_pkg::COORD_BITS-1], in_item.point_y}
		- {query_y[nks_pkg::COORD_BITS-1], query_y};
	assign dz = {in_item.point_z[nks_pkg::COORD_BITS-1], in_item.point_z}
		- {query_z[nks_pkg::COORD_BITS-1], query_z};

	// Valid bits of the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_take;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Stage one keeps the magnitudes, which always fit in 16 bits.
	always_ff @(posedge clk) begin
		mx_s1   <= dx[nks_pkg::COORD_BITS] ? nks_pkg::COORD_BITS'(-dx)
			: dx[nks_pkg::COORD_BITS-1:0];
		my_s1   <= dy[nks_pkg::COORD_BITS] ? nks_pkg::COORD_BITS'(-dy)
			: dy[nks_pkg::COORD_BITS-1:0];
		mz_s1   <= dz[nks_pkg::COORD_BITS] ? nks_pkg::COORD_BITS'(-dz)
			: dz[nks_pkg::COORD_BITS-1:0];
		id_s1   <= in_item.point_id;
		last_s1 <= in_item.batch_end;
	end

	// Stage two squares each axis.
	always_ff @(posedge clk) begin
		sx_s2   <= nks_pkg::SQ_BITS'(mx_s1) * nks_pkg::SQ_BITS'(mx_s1);
		sy_s2   <= nks_pkg::SQ_BITS'(my_s1) * nks_pkg::SQ_BITS'(my_s1);
		sz_s2   <= nks_pkg::SQ_BITS'(mz_s1) * nks_pkg::SQ_BITS'(mz_s1);
		id_s2   <= id_s1;
		last_s2 <= last_s1;
	end

	// Stage three sums the squares; the total is exact in 34 bits.
	always_ff @(posedge clk) begin
		dist_s3 <= nks_pkg::DIST_BITS'(sx_s2) + nks_pkg::DIST_BITS'(sy_s2)
			+ nks_pkg::DIST_BITS'(sz_s2);
		id_s3   <= id_s2;
		last_s3 <= last_s2;
	end

	assign cand = '{valid: vld_s3, last: last_s3, id: id_s3, distance: dist_s3};

endmodule

@@ rtl/nks_cell.sv @@
// One cell of the sorted keep chain: holds one kept point and hands entries on.
// Depends on nks_pkg.
module nks_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  nks_pkg::cell_ctl_t ctl,
	input  nks_pkg::cand_t     cand,
	input  logic               prev_take,
	input  nks_pkg::entry_t    prev_entry,
	input  nks_pkg::entry_t    next_entry,
	output logic               take,
	output nks_pkg::entry_t    entry
);

	nks_pkg::entry_t entry_q;

	// The new point goes in front of this entry when it is strictly nearer;
	// equal distances keep the earlier arrival in front.
	assign take = !entry_q.valid || (cand.distance < entry_q.distance);

	// Insert: shift down behind the new point or take it in.
	// Drain: move one place towards the head.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (ctl.ins) begin
			if (take && prev_take) begin
				entry_q <= prev_entry;
			end else if (take) begin
				entry_q <= '{valid: 1'b1, id: cand.id, distance: cand.distance};
			end
		end else if (ctl.shift) begin
			entry_q <= next_entry;
		end
	end

	assign entry = entry_q;

endmodule

@@ rtl/nearest_k_point_selector.sv @@
// Top level of the nearest-K point selector: query registers, distance unit,
// keep chain and result register. Depends on nks_pkg, nks_dist and nks_cell.
//
// Usage: write the query position through the configuration channel
// (cfg_valid, cfg_ready, cfg_index, cfg_data; indexes 0 to 2 are x, y, z,
// any other index is ignored). cfg_ready is always high. Candidate points
// arrive on in_valid/in_ready/in_data, one transfer per cycle while in_ready
// is high. Each point passes a three-stage distance pipeline and is then
// inserted into a chain of eight cells that keeps the nearest points sorted,
// ties in arrival order. The transfer that carries batch_end closes the
// batch: in_ready falls and stays low until the last result of that batch
// has been loaded into the output register. Once the closing point has left
// the distance pipeline and been inserted, the chain drains into the output
// register: results follow one per cycle while out_ready is high, nearest
// first, final_result marking the last. When out_ready is low the result
// register holds and the chain waits; nothing is lost.
// Reset clears the query position to zero and empties the chain.
module nearest_k_point_selector (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [nks_pkg::CFG_BITS-1:0] cfg_index,
	input  logic [nks_pkg::COORD_BITS-1:0] cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  nks_pkg::in_t                 in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output nks_pkg::out_t                out_data
);

	nks_pkg::coord_t    query_x_q, query_y_q, query_z_q;
	nks_pkg::cand_t     cand;
	nks_pkg::cell_ctl_t ctl;
	nks_pkg::entry_t    entries [nks_pkg::KEEP_COUNT];
	nks_pkg::entry_t    prev_e  [nks_pkg::KEEP_COUNT];
	nks_pkg::entry_t    next_e  [nks_pkg::KEEP_COUNT];
	logic [nks_pkg::KEEP_COUNT-1:0] takes, prev_t;
	logic                           busy_q, drain_q, out_valid_q, emit, in_take, last_out;
	logic [nks_pkg::RANK_BITS-1:0]  rank_q;
	nks_pkg::out_t                  out_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = !busy_q;
	assign in_take   = in_valid && !busy_q;

	// Query position registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_x_q <= '0;
			query_y_q <= '0;
			query_z_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				nks_pkg::CFG_QUERY_X: query_x_q <= cfg_data;
				nks_pkg::CFG_QUERY_Y: query_y_q <= cfg_data;
				nks_pkg::CFG_QUERY_Z: query_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	nks_dist u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_take (in_take),
		.in_item (in_data),
		.query_x (query_x_q),
		.query_y (query_y_q),
		.query_z (query_z_q),
		.cand    (cand)
	);

	// Insertions and drain shifts never fall in the same cycle.
	assign emit = drain_q && (!out_valid_q || out_ready);
	assign ctl  = '{ins: cand.valid, shift: emit};

	// Neighbour wiring of the chain; the ends see an empty entry.
	always_comb begin
		for (int i = 0; i < nks_pkg::KEEP_COUNT; i++) begin
			prev_e[i] = (i == 0) ? '0 : entries[(i == 0) ? 0 : i-1];
			prev_t[i] = (i == 0) ? 1'b0 : takes[(i == 0) ? 0 : i-1];
			next_e[i] = (i == nks_pkg::KEEP_COUNT-1) ? '0
				: entries[(i == nks_pkg::KEEP_COUNT-1) ? i : i+1];
		end
	end

	for (genvar g = 0; g < nks_pkg::KEEP_COUNT; g++) begin : g_cell
		nks_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.cand       (cand),
			.prev_take  (prev_t[g]),
			.prev_entry (prev_e[g]),
			.next_entry (next_e[g]),
			.take       (takes[g]),
			.entry      (entries[g])
		);
	end

	// The head entry is the last of the batch when the one behind it is empty.
	assign last_out = (nks_pkg::KEEP_COUNT == 1) ? 1'b1 : !next_e[0].valid;

	// Batch control: block input from the closing transfer to the last result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			drain_q <= 1'b0;
			rank_q  <= '0;
		end else begin
			if (in_take && in_data.batch_end) begin
				busy_q <= 1'b1;
			end else if (emit && last_out) begin
				busy_q <= 1'b0;
			end
			if (cand.valid && cand.last) begin
				drain_q <= 1'b1;
			end else if (emit && last_out) begin
				drain_q <= 1'b0;
			end
			if (emit) begin
				rank_q <= last_out ? '0 : rank_q + 1'b1;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.rank         <= rank_q;
			out_q.chosen_id    <= entries[0].id;
			out_q.distance_sq  <= entries[0].distance;
			out_q.final_result <= last_out;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
